[hw/rtl/cstp_pkg.sv]
// Shared types, constants and codes of the call stack time profiler.
`default_nettype none
package cstp_pkg;
    localparam int STACK_DEPTH  = 64;
    localparam int FUNC_ENTRIES = 256;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(FUNC_ENTRIES);
    localparam int SP_ALIGN = 4;
    localparam int SP_SLACK = 256;

    localparam logic [1:0] OP_ENTER = 2'd0;
    localparam logic [1:0] OP_LEAVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_STK_FULL = 3'd2;
    localparam logic [2:0] ST_TBL_FULL = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] func_address;
        logic [31:0] stack_pointer;
        logic [31:0] return_address;
        logic [63:0] timestamp;
        logic [7:0]  read_index;
    } in_word_t;

    typedef struct packed {
        logic [31:0] return_address_out;
        logic [6:0]  stack_level;
        logic [2:0]  status;
        logic        entry_valid;
        logic [31:0] entry_address;
        logic [63:0] call_count;
        logic [63:0] total_ticks;
        logic [63:0] pure_ticks;
    } out_word_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // latch input word
        logic scan_rd;    // read table at scan index
        logic scan_step;  // advance scan index
        logic alloc;      // write new table entry
        logic push;       // write frame and bump depth
        logic pop_rd;     // read top frame
        logic pop_trd;    // read table entry of the popped frame
        logic pop_wr;     // update table, caller, pop
        logic read_rd;    // read entry for op 2
        logic finish;     // form result word
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] op;
        logic       stack_full;
        logic       stack_empty;
        logic       table_full;
        logic       scan_done;   // scan index reached functions_known
        logic       scan_hit;    // registered table read matches
        logic       frame_match; // popped frame matched sp
        logic       now_empty;   // stack empty after pop
    } stat_t;
endpackage
`default_nettype wire

[hw/rtl/cstp_ctrl.sv]
// Controller state machine of the call stack time profiler.
`default_nettype none
module cstp_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire cstp_pkg::stat_t  st,
    output cstp_pkg::cmd_t        cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SCHK  = 4'd3;
    localparam logic [3:0] S_PUSH  = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PWR   = 4'd6;
    localparam logic [3:0] S_RRD   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_ALLOC = 4'd10;
    localparam logic [3:0] S_PTR   = 4'd11;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    assign s_ready = aresetn && (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid && s_ready) begin
                cmd.load = 1'b1;
                state_next = S_DISP;
            end
            S_DISP: begin
                if (st.op == cstp_pkg::OP_ENTER) begin
                    state_next = st.stack_full ? S_FIN : S_SCAN;
                end else if (st.op == cstp_pkg::OP_LEAVE) begin
                    state_next = st.stack_empty ? S_FIN : S_PRD;
                end else if (st.op == cstp_pkg::OP_READ) begin
                    state_next = S_RRD;
                end else begin
                    state_next = S_FIN;
                end
            end
            // linear lookup over the known functions
            S_SCAN: begin
                if (st.scan_done) begin
                    state_next = st.table_full ? S_FIN : S_ALLOC;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next = S_SCHK;
                end
            end
            S_SCHK: begin
                if (st.scan_hit) begin
                    state_next = S_PUSH;
                end else begin
                    cmd.scan_step = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_ALLOC: begin
                cmd.alloc = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                cmd.push = 1'b1;
                state_next = S_FIN;
            end
            // pop loop
            S_PRD: begin
                cmd.pop_rd = 1'b1;
                state_next = S_PTR;
            end
            S_PTR: begin
                cmd.pop_trd = 1'b1;
                state_next = S_PWR;
            end
            S_PWR: begin
                cmd.pop_wr = 1'b1;
                state_next = (st.frame_match || st.now_empty) ? S_FIN : S_PRD;
            end
            S_RRD: begin
                cmd.read_rd = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/cstp_datapath.sv]
// Datapath of the profiler: frame stack, function table and tick arithmetic.
`default_nettype none
module cstp_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cstp_pkg::in_word_t  s_word,
    input  wire cstp_pkg::cmd_t      cmd,
    output cstp_pkg::stat_t          st,
    output cstp_pkg::out_word_t      m_word
);
    localparam int SW = cstp_pkg::SW;
    localparam int FW = cstp_pkg::FW;

    // frame stack memories
    logic [FW-1:0] fr_idx [cstp_pkg::STACK_DEPTH];
    logic [31:0]   fr_sp  [cstp_pkg::STACK_DEPTH];
    logic [31:0]   fr_ret [cstp_pkg::STACK_DEPTH];
    logic [63:0]   fr_ent [cstp_pkg::STACK_DEPTH];
    logic [63:0]   fr_chd [cstp_pkg::STACK_DEPTH];
    // function table memories
    logic [31:0]   tb_addr [cstp_pkg::FUNC_ENTRIES];
    logic [6:0]    tb_dep  [cstp_pkg::FUNC_ENTRIES];
    logic [63:0]   tb_cnt  [cstp_pkg::FUNC_ENTRIES];
    logic [63:0]   tb_tot  [cstp_pkg::FUNC_ENTRIES];
    logic [63:0]   tb_pur  [cstp_pkg::FUNC_ENTRIES];

    cstp_pkg::in_word_t in_reg;
    logic [SW:0]   used_reg;
    logic [FW:0]   known_reg;
    logic [FW:0]   scan_reg;
    logic [FW-1:0] slot_reg;
    logic          scan_hit_reg;
    logic [SW:0]   used_base_reg;
    logic [2:0]    status_reg;
    logic [31:0]   ret_reg;
    // registered read data
    logic [31:0]   rd_taddr_reg;
    logic [6:0]    rd_dep_reg;
    logic [63:0]   rd_cnt_reg, rd_tot_reg, rd_pur_reg;
    logic [FW-1:0] rd_fidx_reg;
    logic [31:0]   rd_fsp_reg, rd_fret_reg;
    logic [63:0]   rd_fent_reg, rd_fchd_reg, rd_pchd_reg;
    logic          rvalid_reg;

    logic [SW-1:0] top;
    logic [63:0]   delta;
    logic [31:0]   diff;
    logic [6:0]    dep_dec;
    logic          fmatch;
    logic [FW-1:0] push_slot;

    assign top      = SW'(used_reg - 1'b1);
    assign delta    = in_reg.timestamp - rd_fent_reg;
    assign diff     = in_reg.stack_pointer - rd_fsp_reg;
    assign dep_dec  = rd_dep_reg - 7'd1;
    assign fmatch   = (rd_fsp_reg == in_reg.stack_pointer) ||
                      ((rd_fsp_reg < in_reg.stack_pointer) && (diff[1:0] == 2'd0) &&
                       (diff < 32'(cstp_pkg::SP_SLACK)));
    assign push_slot = FW'(scan_reg);

    assign st.op          = in_reg.operation;
    assign st.stack_full  = (used_reg >= (SW+1)'(cstp_pkg::STACK_DEPTH));
    assign st.stack_empty = (used_reg == '0);
    assign st.table_full  = (known_reg >= (FW+1)'(cstp_pkg::FUNC_ENTRIES));
    assign st.scan_done   = (scan_reg >= known_reg);
    assign st.scan_hit    = (rd_taddr_reg == in_reg.func_address);
    assign st.frame_match = fmatch;
    assign st.now_empty   = (used_reg == (SW+1)'(1));

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            known_reg <= '0;
        end else begin
            if (cmd.alloc) known_reg <= known_reg + 1'b1;
            if (cmd.push)  used_reg  <= used_reg + 1'b1;
            if (cmd.pop_wr) used_reg <= used_reg - 1'b1;
        end
    end

    // event registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg     <= s_word;
            scan_reg   <= '0;
            status_reg <= cstp_pkg::ST_OK;
            ret_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        if (cmd.scan_step) scan_reg <= scan_reg + 1'b1;
        if (cmd.pop_wr) begin
            ret_reg <= rd_fret_reg;
            if (!fmatch) status_reg <= cstp_pkg::ST_MISMATCH;
        end
        if (cmd.read_rd)
            rvalid_reg <= ({1'b0, in_reg.read_index} < 9'(known_reg));
    end

    // table port: one read and one write per cycle
    always_ff @(posedge aclk) begin
        logic [FW-1:0] ra;
        ra = cmd.pop_trd ? rd_fidx_reg :
             cmd.read_rd ? in_reg.read_index[FW-1:0] : FW'(scan_reg);
        if (cmd.scan_rd || cmd.pop_trd || cmd.read_rd) begin
            rd_taddr_reg <= tb_addr[ra];
            rd_dep_reg   <= tb_dep[ra];
            rd_cnt_reg   <= tb_cnt[ra];
            rd_tot_reg   <= tb_tot[ra];
            rd_pur_reg   <= tb_pur[ra];
        end
        if (cmd.alloc) begin
            tb_addr[FW'(known_reg)] <= in_reg.func_address;
            tb_dep[FW'(known_reg)]  <= '0;
            tb_cnt[FW'(known_reg)]  <= '0;
            tb_tot[FW'(known_reg)]  <= '0;
            tb_pur[FW'(known_reg)]  <= '0;
        end else if (cmd.push) begin
            tb_dep[slot_reg] <= scan_hit_reg ? rd_dep_reg + 7'd1 : 7'd1;
        end else if (cmd.pop_wr) begin
            tb_dep[rd_fidx_reg] <= dep_dec;
            tb_cnt[rd_fidx_reg] <= rd_cnt_reg + 64'd1;
            if (dep_dec == 7'd0) tb_tot[rd_fidx_reg] <= rd_tot_reg + delta;
            tb_pur[rd_fidx_reg] <= rd_pur_reg + (delta - rd_fchd_reg);
        end
    end

    // remember whether push follows a hit (depth from read) or an allocation
    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            slot_reg     <= FW'(known_reg);
            scan_hit_reg <= 1'b0;
        end else if (cmd.scan_rd) begin
            slot_reg     <= push_slot;
            scan_hit_reg <= 1'b1;
        end
    end

    // frame stack port
    always_ff @(posedge aclk) begin
        if (cmd.pop_rd) begin
            rd_fidx_reg <= fr_idx[top];
            rd_fsp_reg  <= fr_sp[top];
            rd_fret_reg <= fr_ret[top];
            rd_fent_reg <= fr_ent[top];
            rd_fchd_reg <= fr_chd[top];
            rd_pchd_reg <= fr_chd[SW'(top - 1'b1)];
        end
        if (cmd.push) begin
            fr_idx[SW'(used_reg)] <= slot_reg;
            fr_sp[SW'(used_reg)]  <= in_reg.stack_pointer;
            fr_ret[SW'(used_reg)] <= in_reg.return_address;
            fr_ent[SW'(used_reg)] <= in_reg.timestamp;
            fr_chd[SW'(used_reg)] <= '0;
        end else if (cmd.pop_wr && (used_reg > (SW+1)'(1))) begin
            fr_chd[SW'(top - 1'b1)] <= rd_pchd_reg + delta;
        end
    end

    // stack level at event start, to tell dropped enters and empty leaves
    always_ff @(posedge aclk) begin
        if (cmd.load) used_base_reg <= used_reg;
    end

    // result word
    always_ff @(posedge aclk) begin
        cstp_pkg::out_word_t res;
        res = '0;
        res.stack_level = 7'(used_reg);
        if (in_reg.operation == cstp_pkg::OP_ENTER) begin
            if (used_reg == used_base_reg)
                res.status = st.stack_full ? cstp_pkg::ST_STK_FULL
                                           : cstp_pkg::ST_TBL_FULL;
        end else if (in_reg.operation == cstp_pkg::OP_LEAVE) begin
            res.return_address_out = ret_reg;
            res.status = (used_base_reg == '0) ? cstp_pkg::ST_EMPTY : status_reg;
        end else if (in_reg.operation == cstp_pkg::OP_READ && rvalid_reg) begin
            res.entry_valid   = 1'b1;
            res.entry_address = rd_taddr_reg;
            res.call_count    = rd_cnt_reg;
            res.total_ticks   = rd_tot_reg;
            res.pure_ticks    = rd_pur_reg;
        end
        if (cmd.finish) m_word <= res;
    end
endmodule
`default_nettype wire

[hw/rtl/call_stack_time_profiler_unit.sv]
// Top level of the call stack time profiler: controller plus datapath.
// From input accept to m_valid: an enter scans the known entries in order and pushes a
// frame on a hit, or allocates an entry first on a miss if the table has room; a full
// stack skips to the result. A leave pops frames until one matches sp or the stack is
// empty. One event at a time: the next word can be accepted in the cycle after the
// result is taken. Reset (aresetn low, synchronous) empties the stack and the table
// at once; memory contents are left as they are, unwritten entries never reach results.
`default_nettype none
module call_stack_time_profiler_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire cstp_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output cstp_pkg::out_word_t      m_data
);
    cstp_pkg::cmd_t  cmd;
    cstp_pkg::stat_t st;

    cstp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .st(st), .cmd(cmd)
    );

    cstp_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_word(s_data), .cmd(cmd),
        .st(st), .m_word(m_data)
    );
endmodule
`default_nettype wire
